@@ sv/efp_pkg.sv @@
package efp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRICTION    = 3'd0,
    REG_START_POS   = 3'd1,
    REG_START_SPEED = 3'd2,
    REG_LOWER       = 3'd3,
    REG_UPPER       = 3'd4,
    REG_REST        = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] FRICTION_RESET = 16'd4096;

  // Base-2 decay rate per unit of friction times milliseconds, split into two 18-bit halves.
  localparam logic [35:0] KDECAY = 36'd50823274627;
  localparam logic [17:0] KDECAY_HI = KDECAY[35:18];
  localparam logic [17:0] KDECAY_LO = KDECAY[17:0];

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [27:0] INV_DRAG_Q16 = 28'd134051471;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam int unsigned SERIES_TERMS = 20;

  // Displacement divider: 44-bit dividend, four quotient bits per stage.
  localparam int unsigned DIV_W = 44;
  localparam int unsigned DIV_STEP = 4;
  localparam int unsigned POS_W = DIV_W + 2;

  localparam int unsigned LATENCY = 58;

endpackage

@@ sv/exponential_fling_position_core.sv @@
// Fling position core: each transfer on start_i carries the milliseconds since a fling began,
// and at the end of the pipeline done_o strobes for one cycle with the clamped position,
// the velocity and the rest flag. A new item is taken in every cycle and busy_o stays low.
// The pipeline holds the 20-term exponential series (two stages per later term) and the
// displacement divider that retires four quotient bits per stage. The receiver cannot stall.
module exponential_fling_position_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TIME_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [TIME_BITS-1:0]               elapsed_ms_i,
  output logic                               done_o,
  output logic signed [31:0]                 position_o,
  output logic signed [31:0]                 speed_o,
  output logic                               at_rest_o,
  input  logic                               cfg_we_i,
  input  logic [efp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [efp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned QW = 16 + TIME_BITS;
  localparam int unsigned QHW = QW - 24;
  localparam int unsigned HHW = QHW + 18;
  localparam int unsigned N = efp_pkg::SERIES_TERMS;
  localparam int unsigned DW = efp_pkg::DIV_W;
  localparam int unsigned PW = efp_pkg::POS_W;
  localparam logic [30:0] REST_RESET = 31'(64'd20 << FRAC_BITS);

  logic [15:0] friction_q;
  logic [31:0] start_pos_q;
  logic [31:0] start_speed_q;
  logic [31:0] lower_q;
  logic [31:0] upper_q;
  logic [30:0] rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      friction_q <= efp_pkg::FRICTION_RESET;
      start_pos_q <= 32'd0;
      start_speed_q <= 32'd0;
      lower_q <= 32'h8000_0000;
      upper_q <= 32'h7FFF_FFFF;
      rest_q <= REST_RESET;
    end else if (cfg_we_i) begin
      unique case (efp_pkg::cfg_idx_e'(cfg_idx_i))
        efp_pkg::REG_FRICTION:    friction_q <= cfg_wdata_i[15:0];
        efp_pkg::REG_START_POS:   start_pos_q <= cfg_wdata_i;
        efp_pkg::REG_START_SPEED: start_speed_q <= cfg_wdata_i;
        efp_pkg::REG_LOWER:       lower_q <= cfg_wdata_i;
        efp_pkg::REG_UPPER:       upper_q <= cfg_wdata_i;
        efp_pkg::REG_REST:        rest_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  logic [15:0] gain;
  logic        neg;
  logic [31:0] mag;
  logic        accept;

  assign gain = (friction_q == 16'd0) ? 16'd1 : friction_q;
  assign neg = start_speed_q[31];
  assign mag = neg ? (~start_speed_q + 32'd1) : start_speed_q;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Decay exponent b = q * KDECAY / 2^24 in Q32.
  logic [QW-1:0]  q_q;
  logic           v1_q;
  logic [HHW-1:0] hh_q;
  logic [HHW-1:0] hl_q;
  logic [41:0]    lh_q;
  logic [41:0]    ll_q;
  logic           v2_q;
  logic [31:0]    r3_q;
  logic [5:0]     n3_q;
  logic           z3_q;
  logic           v3_q;
  logic [59:0]    lo_sum;
  logic [63:0]    b_d;
  logic [63:0]    xp;

  assign lo_sum = {lh_q, 18'd0} + 60'(ll_q);
  assign b_d = 64'({hh_q, 18'd0}) + 64'(hl_q) + 64'(lo_sum[59:24]);
  assign xp = 64'(r3_q) * 64'(efp_pkg::LN2_Q32);

  logic [31:0] term_q [1:N];
  logic [33:0] st_q [1:N];
  logic [31:0] tx_q [1:N];
  logic [5:0]  tn_q [1:N];
  logic        tz_q [1:N];
  logic        tv_q [1:N];
  logic [31:0] pp_q [2:N];
  logic [33:0] ps_q [2:N];
  logic [31:0] px_q [2:N];
  logic [5:0]  pn_q [2:N];
  logic        pz_q [2:N];
  logic        pv_q [2:N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      tv_q[1] <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      tv_q[1] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= QW'(gain) * QW'(elapsed_ms_i);
    hh_q <= HHW'(q_q[QW-1:24]) * HHW'(efp_pkg::KDECAY_HI);
    hl_q <= HHW'(q_q[QW-1:24]) * HHW'(efp_pkg::KDECAY_LO);
    lh_q <= 42'(q_q[23:0]) * 42'(efp_pkg::KDECAY_HI);
    ll_q <= 42'(q_q[23:0]) * 42'(efp_pkg::KDECAY_LO);
    r3_q <= b_d[31:0];
    n3_q <= b_d[37:32];
    z3_q <= (b_d[63:32] >= 32'd33);
    term_q[1] <= xp[63:32];
    st_q[1] <= 34'(efp_pkg::ONE_Q32);
    tx_q[1] <= xp[63:32];
    tn_q[1] <= n3_q;
    tz_q[1] <= z3_q;
  end

  // Taylor series of e^-x: term i = ((term i-1 * x) >> 32) / i, signs alternating.
  for (genvar i = 2; i <= N; i++) begin : g_term
    localparam int unsigned L = $clog2(i);
    localparam int unsigned SH = 32 + L;
    localparam logic [63:0] MF = ((64'd1 << SH) / i) + 64'd1;
    localparam logic [33:0] M = MF[33:0];
    localparam bit SUB = ((i - 1) % 2) == 1;

    logic [63:0] mul_p;
    logic [69:0] mul_t;
    logic [33:0] sum_d;

    assign mul_p = 64'(term_q[i-1]) * 64'(tx_q[i-1]);
    assign mul_t = 70'(pp_q[i]) * 70'(M);
    assign sum_d = SUB ? (st_q[i-1] - 34'(term_q[i-1])) : (st_q[i-1] + 34'(term_q[i-1]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[i] <= 1'b0;
        tv_q[i] <= 1'b0;
      end else begin
        pv_q[i] <= tv_q[i-1];
        tv_q[i] <= pv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      pp_q[i] <= mul_p[63:32];
      ps_q[i] <= sum_d;
      px_q[i] <= tx_q[i-1];
      pn_q[i] <= tn_q[i-1];
      pz_q[i] <= tz_q[i-1];
      term_q[i] <= mul_t[SH +: 32];
      st_q[i] <= ps_q[i];
      tx_q[i] <= px_q[i];
      tn_q[i] <= pn_q[i];
      tz_q[i] <= pz_q[i];
    end
  end

  localparam bit LAST_SUB = (N % 2) == 1;

  logic [33:0] sum_n;
  logic [32:0] e_d;
  logic [32:0] e_q;
  logic        ve_q;

  assign sum_n = LAST_SUB ? (st_q[N] - 34'(term_q[N])) : (st_q[N] + 34'(term_q[N]));
  assign e_d = tz_q[N] ? 33'd0 : 33'(sum_n >> tn_q[N]);

  // Speed and the decayed part of the velocity, then the scaled displacement numerator.
  logic [32:0] one_minus_e;
  logic [64:0] vm_prod;
  logic [64:0] pm_prod;
  logic [31:0] vmag_q;
  logic [31:0] p_q;
  logic        vm_valid_q;
  logic [59:0] nd_prod;
  logic [DW-1:0] nd_q;
  logic [31:0] nd_vmag_q;
  logic        nd_valid_q;

  assign one_minus_e = efp_pkg::ONE_Q32 - e_q;
  assign vm_prod = 65'(mag) * 65'(e_q);
  assign pm_prod = 65'(mag) * 65'(one_minus_e);
  assign nd_prod = 60'(p_q) * 60'(efp_pkg::INV_DRAG_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vm_valid_q <= 1'b0;
      nd_valid_q <= 1'b0;
    end else begin
      ve_q <= tv_q[N];
      vm_valid_q <= ve_q;
      nd_valid_q <= vm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    vmag_q <= vm_prod[63:32];
    p_q <= pm_prod[63:32];
    nd_q <= nd_prod[59:16];
    nd_vmag_q <= vmag_q;
  end

  logic          dv_valid;
  logic [DW-1:0] dmag;
  logic [31:0]   dv_vmag;

  efp_divider #(
    .DIVIDEND_W(DW),
    .DIVISOR_W (16),
    .TAG_W     (32)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (nd_valid_q),
    .dividend_i (nd_q),
    .divisor_i  (gain),
    .tag_i      (nd_vmag_q),
    .out_valid_o(dv_valid),
    .quotient_o (dmag),
    .tag_o      (dv_vmag)
  );

  // Add the displacement to the start position, then clamp and flag.
  logic signed [PW-1:0] x0_ext;
  logic signed [PW-1:0] d_ext;
  logic signed [PW-1:0] pos_q;
  logic [31:0]          s_vmag_q;
  logic                 s_valid_q;
  logic signed [PW-1:0] lo_ext;
  logic signed [PW-1:0] hi_ext;
  logic signed [PW-1:0] clamp_lo;
  logic signed [PW-1:0] clamp_hi;
  logic                 rest;

  assign x0_ext = PW'(signed'(start_pos_q));
  assign d_ext = signed'(PW'(dmag));
  assign lo_ext = PW'(signed'(lower_q));
  assign hi_ext = PW'(signed'(upper_q));
  assign clamp_lo = (pos_q < lo_ext) ? lo_ext : pos_q;
  assign clamp_hi = (clamp_lo > hi_ext) ? hi_ext : clamp_lo;
  assign rest = (clamp_hi >= hi_ext) || (clamp_hi <= lo_ext) || (s_vmag_q < 32'(rest_q));

  logic done_q;
  logic at_rest_q;
  logic signed [31:0] position_q;
  logic signed [31:0] speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      done_q <= 1'b0;
      at_rest_q <= 1'b0;
    end else begin
      s_valid_q <= dv_valid;
      done_q <= s_valid_q;
      at_rest_q <= s_valid_q & rest;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= neg ? (x0_ext - d_ext) : (x0_ext + d_ext);
    s_vmag_q <= dv_vmag;
    position_q <= clamp_hi[31:0];
    speed_q <= neg ? signed'(~s_vmag_q + 32'd1) : signed'(s_vmag_q);
  end

  assign done_o = done_q;
  assign at_rest_o = at_rest_q;
  assign position_o = position_q;
  assign speed_o = speed_q;

endmodule

@@ sv/efp_divider.sv @@
module efp_divider #(
  parameter int unsigned DIVIDEND_W = 44,
  parameter int unsigned DIVISOR_W = 16,
  parameter int unsigned TAG_W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  out_valid_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [TAG_W-1:0]      tag_o
);

  localparam int unsigned STEP = efp_pkg::DIV_STEP;
  localparam int unsigned STAGES = (DIVIDEND_W + STEP - 1) / STEP;
  localparam int unsigned EXT_W = STAGES * STEP;

  logic [EXT_W-1:0]     w_q [1:STAGES];
  logic [DIVISOR_W-1:0] r_q [1:STAGES];
  logic [TAG_W-1:0]     t_q [1:STAGES];
  logic                 v_q [1:STAGES];

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    logic [EXT_W-1:0]     w_in;
    logic [EXT_W-1:0]     w_d;
    logic [DIVISOR_W-1:0] r_in;
    logic [DIVISOR_W-1:0] r_d;
    logic [TAG_W-1:0]     t_in;
    logic                 v_in;

    if (s == 1) begin : g_first
      assign w_in = EXT_W'(dividend_i);
      assign r_in = '0;
      assign t_in = tag_i;
      assign v_in = in_valid_i;
    end else begin : g_next
      assign w_in = w_q[s-1];
      assign r_in = r_q[s-1];
      assign t_in = t_q[s-1];
      assign v_in = v_q[s-1];
    end

    always_comb begin
      logic [DIVISOR_W:0] trial;
      w_d = w_in;
      r_d = r_in;
      for (int k = 0; k < STEP; k++) begin
        trial = {r_d, w_d[EXT_W-1]};
        w_d = {w_d[EXT_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          r_d = DIVISOR_W'(trial - {1'b0, divisor_i});
          w_d[0] = 1'b1;
        end else begin
          r_d = trial[DIVISOR_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      w_q[s] <= w_d;
      r_q[s] <= r_d;
      t_q[s] <= t_in;
    end
  end

  assign out_valid_o = v_q[STAGES];
  assign quotient_o = w_q[STAGES][DIVIDEND_W-1:0];
  assign tag_o = t_q[STAGES];

endmodule

@@ sv/efp_checker.sv @@
module efp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic at_rest_o
);

  // Every accepted transfer produces its result after the fixed pipeline latency.
  a_result_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(efp_pkg::LATENCY) done_o)
    else $error("accepted item produced no result after the pipeline latency");

  // No result appears without an accepted transfer the pipeline latency earlier.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, efp_pkg::LATENCY))
    else $error("result strobe without a matching accepted item");

  // The rest flag is only raised together with a result.
  a_rest_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !at_rest_o)
    else $error("rest flag raised outside a result cycle");

endmodule

bind exponential_fling_position_core efp_checker u_efp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .at_rest_o(at_rest_o)
);
